// File: hdl/hac_pkg.sv
// shared constants and types for the hysteresis actuator controller
package hac_pkg;

	// telemetry frame layout
	localparam int unsigned FRAME_LEN = 12;
	localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

	localparam logic [7:0] HDR0 = 8'h55;
	localparam logic [7:0] HDR1 = 8'hAA;
	localparam logic [7:0] TAIL = 8'hBB;

	// remote alarm byte that raises the alarm
	localparam logic [7:0] ALARM_CODE = 8'd1;

	// x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
	localparam logic [15:0] DIV10_MUL   = 16'd52429;
	localparam int unsigned DIV10_SHIFT = 19;
	localparam int unsigned WHOLE_W     = 13;

	// register map, byte address = 4 * index
	localparam int unsigned ADDR_W = 5;
	localparam logic [2:0] REG_TEMP_HIGH_LIMIT = 3'd0;
	localparam logic [2:0] REG_TEMP_HIGH_BAND  = 3'd1;
	localparam logic [2:0] REG_TEMP_LOW_LIMIT  = 3'd2;
	localparam logic [2:0] REG_TEMP_LOW_BAND   = 3'd3;
	localparam logic [2:0] REG_HUMID_LOW_LIMIT = 3'd4;
	localparam logic [2:0] REG_HUMID_BAND      = 3'd5;
	localparam logic [2:0] REG_ALCOHOL_LIMIT   = 3'd6;
	localparam logic [2:0] REG_ALCOHOL_BAND    = 3'd7;

	// register reset values
	localparam logic [7:0]  RST_TEMP_HIGH_LIMIT = 8'd30;
	localparam logic [7:0]  RST_TEMP_HIGH_BAND  = 8'd2;
	localparam logic [7:0]  RST_TEMP_LOW_LIMIT  = 8'd20;
	localparam logic [7:0]  RST_TEMP_LOW_BAND   = 8'd5;
	localparam logic [7:0]  RST_HUMID_LOW_LIMIT = 8'd40;
	localparam logic [7:0]  RST_HUMID_BAND      = 8'd5;
	localparam logic [15:0] RST_ALCOHOL_LIMIT   = 16'd500;
	localparam logic [15:0] RST_ALCOHOL_BAND    = 16'd20;

	typedef logic [7:0] byte_t;

	// divide a 16-bit reading by ten
	function automatic logic [WHOLE_W-1:0] div10(input logic [15:0] x);
		logic [31:0] prod;
		prod = 32'(x) * 32'(DIV10_MUL);
		return prod[DIV10_SHIFT +: WHOLE_W];
	endfunction

endpackage

// File: hdl/hysteresis_actuator_controller.sv
// hysteresis actuator controller: tick input stage, rule logic, frame serializer
// latency: a tick taken into the input register loads its frame into the frame register
// once the serializer is free or sends its last byte; the first frame byte is shown from then on
// throughput: the frame leaves one byte a beat, stalled while out_stall is high;
// one further tick waits in the input register while a frame drains
// reset: registers return to their defaults, held readings and levels clear
module hysteresis_actuator_controller
	import hac_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// tick input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              new_reading,
	input  logic [15:0]       temperature,
	input  logic [15:0]       humidity,
	input  logic [15:0]       alcohol,
	input  logic [7:0]        alarm_code,
	// frame output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        frame_byte,
	output logic              frame_last,
	output logic              fan_on,
	output logic              heater_on,
	output logic              humidifier_on,
	output logic              beep
);

	// configuration registers
	logic [7:0]  temp_high_limit_q, temp_high_band_q, temp_low_limit_q, temp_low_band_q;
	logic [7:0]  humid_low_limit_q, humid_band_q;
	logic [15:0] alcohol_limit_q, alcohol_band_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_high_limit_q <= RST_TEMP_HIGH_LIMIT;
			temp_high_band_q  <= RST_TEMP_HIGH_BAND;
			temp_low_limit_q  <= RST_TEMP_LOW_LIMIT;
			temp_low_band_q   <= RST_TEMP_LOW_BAND;
			humid_low_limit_q <= RST_HUMID_LOW_LIMIT;
			humid_band_q      <= RST_HUMID_BAND;
			alcohol_limit_q   <= RST_ALCOHOL_LIMIT;
			alcohol_band_q    <= RST_ALCOHOL_BAND;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_TEMP_HIGH_LIMIT: temp_high_limit_q <= pwdata[7:0];
				REG_TEMP_HIGH_BAND:  temp_high_band_q  <= pwdata[7:0];
				REG_TEMP_LOW_LIMIT:  temp_low_limit_q  <= pwdata[7:0];
				REG_TEMP_LOW_BAND:   temp_low_band_q   <= pwdata[7:0];
				REG_HUMID_LOW_LIMIT: humid_low_limit_q <= pwdata[7:0];
				REG_HUMID_BAND:      humid_band_q      <= pwdata[7:0];
				REG_ALCOHOL_LIMIT:   alcohol_limit_q   <= pwdata[15:0];
				REG_ALCOHOL_BAND:    alcohol_band_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (cfg_idx)
			REG_TEMP_HIGH_LIMIT: prdata = 32'(temp_high_limit_q);
			REG_TEMP_HIGH_BAND:  prdata = 32'(temp_high_band_q);
			REG_TEMP_LOW_LIMIT:  prdata = 32'(temp_low_limit_q);
			REG_TEMP_LOW_BAND:   prdata = 32'(temp_low_band_q);
			REG_HUMID_LOW_LIMIT: prdata = 32'(humid_low_limit_q);
			REG_HUMID_BAND:      prdata = 32'(humid_band_q);
			REG_ALCOHOL_LIMIT:   prdata = 32'(alcohol_limit_q);
			REG_ALCOHOL_BAND:    prdata = 32'(alcohol_band_q);
			default:             prdata = '0;
		endcase
	end

	// input register
	logic        valid_s1;
	logic        new_reading_s1;
	logic [15:0] temperature_s1, humidity_s1, alcohol_s1;
	logic [7:0]  alarm_s1;

	// frame serializer state
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	byte_t            frame_q [FRAME_LEN];
	logic             beep_q;

	logic out_beat, frame_done, advance, in_beat;

	assign out_beat   = busy_q && !out_stall;
	assign frame_done = out_beat && (idx_q == LAST_IDX);
	assign advance    = valid_s1 && (!busy_q || frame_done);
	assign in_stall   = valid_s1 && !advance;
	assign in_beat    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			new_reading_s1 <= new_reading;
			temperature_s1 <= temperature;
			humidity_s1    <= humidity;
			alcohol_s1     <= alcohol;
			alarm_s1       <= alarm_code;
		end
	end

	// held readings and actuator levels
	logic [15:0] held_temp_q, held_humid_q, held_alc_q;
	logic [7:0]  held_alarm_q;
	logic        fan_q, heater_q, humid_q;

	logic [15:0]        temp_sel, humid_sel, alc_sel;
	logic [7:0]         alarm_sel;
	logic [WHOLE_W-1:0] t_whole, h_whole;
	logic [8:0]         fan_off_thr, heat_off_thr, hum_off_thr;
	logic [15:0]        alc_off_thr;
	logic               fan_nx, heater_nx, humid_nx, beep_nx;
	byte_t              sum_nx;

	always_comb begin
		temp_sel  = new_reading_s1 ? temperature_s1 : held_temp_q;
		humid_sel = new_reading_s1 ? humidity_s1    : held_humid_q;
		alc_sel   = new_reading_s1 ? alcohol_s1     : held_alc_q;
		alarm_sel = new_reading_s1 ? alarm_s1       : held_alarm_q;
		t_whole   = div10(temp_sel);
		h_whole   = div10(humid_sel);

		fan_off_thr  = {1'b0, temp_high_limit_q} - {1'b0, temp_high_band_q};
		heat_off_thr = {1'b0, temp_low_limit_q} + {1'b0, temp_low_band_q};
		hum_off_thr  = {1'b0, humid_low_limit_q} + {1'b0, humid_band_q};
		alc_off_thr  = alcohol_limit_q - alcohol_band_q;

		fan_nx    = fan_q;
		heater_nx = heater_q;
		humid_nx  = humid_q;
		beep_nx   = 1'b0;

		// temperature rule on the fan; an off threshold below zero never fires
		if (t_whole > WHOLE_W'(temp_high_limit_q)) begin
			fan_nx  = 1'b1;
			beep_nx = 1'b1;
		end else if (!fan_off_thr[8] && (t_whole < WHOLE_W'(fan_off_thr[7:0]))) begin
			fan_nx = 1'b0;
		end

		// heater rule
		if (t_whole < WHOLE_W'(temp_low_limit_q)) begin
			heater_nx = 1'b1;
			beep_nx   = 1'b1;
		end else if (t_whole > WHOLE_W'(heat_off_thr)) begin
			heater_nx = 1'b0;
		end

		// humidifier rule
		if (h_whole < WHOLE_W'(humid_low_limit_q)) begin
			humid_nx = 1'b1;
			beep_nx  = 1'b1;
		end else if (h_whole > WHOLE_W'(hum_off_thr)) begin
			humid_nx = 1'b0;
		end

		// alcohol and alarm rule overrides the fan
		if ((alc_sel >= alcohol_limit_q) || (alarm_sel == ALARM_CODE)) begin
			fan_nx  = 1'b1;
			beep_nx = 1'b1;
		end else if ((alcohol_limit_q >= alcohol_band_q) && (alc_sel < alc_off_thr)) begin
			fan_nx = 1'b0;
		end

		sum_nx = t_whole[7:0] + h_whole[7:0] + alc_sel[15:8] + alc_sel[7:0] + alarm_sel
			+ byte_t'(fan_nx) + byte_t'(humid_nx) + byte_t'(heater_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_temp_q  <= '0;
			held_humid_q <= '0;
			held_alc_q   <= '0;
			held_alarm_q <= '0;
			fan_q        <= 1'b0;
			heater_q     <= 1'b0;
			humid_q      <= 1'b0;
		end else if (advance) begin
			held_temp_q  <= temp_sel;
			held_humid_q <= humid_sel;
			held_alc_q   <= alc_sel;
			held_alarm_q <= alarm_sel;
			fan_q        <= fan_nx;
			heater_q     <= heater_nx;
			humid_q      <= humid_nx;
		end
	end

	// serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (advance) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (frame_done) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (out_beat) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// frame load
	always_ff @(posedge clk) begin
		if (advance) begin
			frame_q[0]  <= HDR0;
			frame_q[1]  <= HDR1;
			frame_q[2]  <= t_whole[7:0];
			frame_q[3]  <= h_whole[7:0];
			frame_q[4]  <= alc_sel[15:8];
			frame_q[5]  <= alc_sel[7:0];
			frame_q[6]  <= alarm_sel;
			frame_q[7]  <= byte_t'(fan_nx);
			frame_q[8]  <= byte_t'(humid_nx);
			frame_q[9]  <= byte_t'(heater_nx);
			frame_q[10] <= sum_nx;
			frame_q[11] <= TAIL;
			beep_q      <= beep_nx;
		end
	end

	// output beat
	assign out_valid     = busy_q;
	assign frame_byte    = frame_q[idx_q];
	assign frame_last    = (idx_q == LAST_IDX);
	assign fan_on        = fan_q;
	assign heater_on     = heater_q;
	assign humidifier_on = humid_q;
	assign beep          = beep_q;

`ifndef SYNTHESIS
	// byte index steps by one on each non-final beat
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && !frame_last && !advance) |=> (busy_q && idx_q == $past(idx_q) + 1'b1))
		else $error("frame index did not advance");

	// a held tick keeps its payload
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(temperature_s1) && $stable(alarm_s1)))
		else $error("held tick lost or changed");

	// checksum byte matches the frame body
	a_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (frame_q[10] == byte_t'(frame_q[2] + frame_q[3] + frame_q[4] + frame_q[5]
			+ frame_q[6] + frame_q[7] + frame_q[8] + frame_q[9])))
		else $error("checksum mismatch");

	// a new frame only loads once the old one is finished
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && busy_q) |-> frame_done)
		else $error("frame overwritten before tail");
`endif

endmodule
